// ===== src/rvcsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RV64 CSR file package
// Shared types, CSR addresses, bit masks and store slot numbers.
// ----------------------------------------------------------------------------
package rvcsr_pkg;

	// Command codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// CSR addresses
	localparam logic [11:0] CSR_MVENDORID  = 12'hF11;
	localparam logic [11:0] CSR_MARCHID    = 12'hF12;
	localparam logic [11:0] CSR_MIMPID     = 12'hF13;
	localparam logic [11:0] CSR_MHARTID    = 12'hF14;
	localparam logic [11:0] CSR_MSTATUS    = 12'h300;
	localparam logic [11:0] CSR_MISA       = 12'h301;
	localparam logic [11:0] CSR_MEDELEG    = 12'h302;
	localparam logic [11:0] CSR_MIDELEG    = 12'h303;
	localparam logic [11:0] CSR_MIE        = 12'h304;
	localparam logic [11:0] CSR_MTVEC      = 12'h305;
	localparam logic [11:0] CSR_MCOUNTEREN = 12'h306;
	localparam logic [11:0] CSR_MSCRATCH   = 12'h340;
	localparam logic [11:0] CSR_MEPC       = 12'h341;
	localparam logic [11:0] CSR_MCAUSE     = 12'h342;
	localparam logic [11:0] CSR_MTVAL      = 12'h343;
	localparam logic [11:0] CSR_MIP        = 12'h344;
	localparam logic [11:0] CSR_MCYCLE     = 12'hB00;
	localparam logic [11:0] CSR_MINSTRET   = 12'hB02;
	localparam logic [11:0] CSR_CYCLE      = 12'hC00;
	localparam logic [11:0] CSR_TIME       = 12'hC01;
	localparam logic [11:0] CSR_INSTRET    = 12'hC02;
	localparam logic [11:0] CSR_SSTATUS    = 12'h100;
	localparam logic [11:0] CSR_SIE        = 12'h104;
	localparam logic [11:0] CSR_STVEC      = 12'h105;
	localparam logic [11:0] CSR_SCOUNTEREN = 12'h106;
	localparam logic [11:0] CSR_SSCRATCH   = 12'h140;
	localparam logic [11:0] CSR_SEPC       = 12'h141;
	localparam logic [11:0] CSR_SCAUSE     = 12'h142;
	localparam logic [11:0] CSR_STVAL      = 12'h143;
	localparam logic [11:0] CSR_SIP        = 12'h144;
	localparam logic [11:0] CSR_SATP       = 12'h180;

	// Masks and constant values
	localparam int unsigned STATUS_W = 23;
	localparam int unsigned IRQ_W    = 12;
	localparam logic [STATUS_W-1:0] MSTATUS_KEEP  = 23'h7E19AA;
	localparam logic [STATUS_W-1:0] SSTATUS_VIEW  = 23'h0C0122;
	localparam logic [STATUS_W-1:0] MSTATUS_RESET = 23'h001800; // MPP = machine
	localparam logic [IRQ_W-1:0]    IRQ_ALL       = 12'hAAA;
	localparam logic [IRQ_W-1:0]    IRQ_SUPER     = 12'h222;
	localparam logic [IRQ_W-1:0]    IRQ_SSIP      = 12'h002;
	localparam logic [63:0]         MISA_VALUE    = 64'h8000_0000_0014_1101;
	localparam logic [3:0]          TRANSLATION_BARE = 4'd0;
	localparam logic [3:0]          TRANSLATION_SV39 = 4'd8;

	// Plain store slots
	localparam int unsigned STORE_DEPTH = 17;
	localparam int unsigned SLOT_W      = $clog2(STORE_DEPTH);
	localparam logic [SLOT_W-1:0] SLOT_MEDELEG    = 5'd0;
	localparam logic [SLOT_W-1:0] SLOT_MIDELEG    = 5'd1;
	localparam logic [SLOT_W-1:0] SLOT_MTVEC      = 5'd2;
	localparam logic [SLOT_W-1:0] SLOT_MCOUNTEREN = 5'd3;
	localparam logic [SLOT_W-1:0] SLOT_MSCRATCH   = 5'd4;
	localparam logic [SLOT_W-1:0] SLOT_MEPC       = 5'd5;
	localparam logic [SLOT_W-1:0] SLOT_MCAUSE     = 5'd6;
	localparam logic [SLOT_W-1:0] SLOT_MTVAL      = 5'd7;
	localparam logic [SLOT_W-1:0] SLOT_MCYCLE     = 5'd8;
	localparam logic [SLOT_W-1:0] SLOT_MINSTRET   = 5'd9;
	localparam logic [SLOT_W-1:0] SLOT_STVEC      = 5'd10;
	localparam logic [SLOT_W-1:0] SLOT_SCOUNTEREN = 5'd11;
	localparam logic [SLOT_W-1:0] SLOT_SSCRATCH   = 5'd12;
	localparam logic [SLOT_W-1:0] SLOT_SEPC       = 5'd13;
	localparam logic [SLOT_W-1:0] SLOT_SCAUSE     = 5'd14;
	localparam logic [SLOT_W-1:0] SLOT_STVAL      = 5'd15;
	localparam logic [SLOT_W-1:0] SLOT_SATP       = 5'd16;

	typedef enum logic [3:0] {
		KIND_NONE,
		KIND_ZERO,
		KIND_MSTATUS,
		KIND_MISA,
		KIND_MIE,
		KIND_MIP,
		KIND_SSTATUS,
		KIND_SIE,
		KIND_SIP,
		KIND_STORE
	} csr_kind_t;

	typedef enum logic [1:0] {
		WMODE_PLAIN,
		WMODE_TVEC,
		WMODE_EPC,
		WMODE_SATP
	} csr_wmode_t;

	typedef struct packed {
		logic              impl;
		csr_kind_t         kind;
		logic [SLOT_W-1:0] slot;
		logic              writable;
		csr_wmode_t        wmode;
	} csr_dec_t;

	typedef struct packed {
		logic        cmd;
		logic [11:0] csr_address;
		logic [63:0] write_data;
	} csr_req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        implemented;
	} csr_rsp_t;

endpackage
`default_nettype wire

// ===== src/rv64_csr_register_file.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RV64 machine/supervisor CSR register file
// Read or write one CSR per item; returns read data and an implemented flag.
// ----------------------------------------------------------------------------
// Usage: busy is always low, so an item is taken on every cycle that start is
// high, one item per clock. The result for an item appears on rsp with done
// high once it has passed the input register and then the result register,
// and stays for one cycle only; the receiver cannot stall it.
// Items act on the state strictly in order: a read sees every earlier write.
// A write returns read_data zero; an unimplemented address returns zero with
// implemented low and changes nothing. Writes to read-only CSRs (IDs, misa,
// cycle, time, instret) are dropped but report implemented. mcycle and
// minstret never count on their own.
// ----------------------------------------------------------------------------
module rv64_csr_register_file (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire rvcsr_pkg::csr_req_t req,
	output logic                     done,
	output rvcsr_pkg::csr_rsp_t      rsp
);
	import rvcsr_pkg::*;

	logic     valid_s1;
	csr_req_t req_s1;
	logic     valid_s2;
	csr_rsp_t rsp_s2;
	csr_dec_t dec;
	logic     we;
	logic [63:0] rdata;

	// Never stall: no stage ever holds an item back
	assign busy = 1'b0;

	// Input register: capture the item on start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			req_s1 <= req;
	end

	rvcsr_decode u_decode (
		.addr (req_s1.csr_address),
		.dec  (dec)
	);

	// Commit the write at the end of stage one so the next item sees it
	assign we = valid_s1 && (req_s1.cmd == CMD_WRITE) && dec.impl;

	rvcsr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.dec    (dec),
		.wdata  (req_s1.write_data),
		.rdata  (rdata)
	);

	// Result register: present for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2.implemented <= dec.impl;
			rsp_s2.read_data   <= (req_s1.cmd == CMD_READ && dec.impl) ? rdata : 64'd0;
		end
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("item result did not appear two cycles after start");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##2 !done)
		else $error("result strobe without an accepted item");
`endif

endmodule
`default_nettype wire

// ===== src/rvcsr_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CSR address decoder
// Maps a 12-bit CSR number to its kind, store slot and write rule.
// ----------------------------------------------------------------------------
module rvcsr_decode (
	input  wire logic [11:0]        addr,
	output rvcsr_pkg::csr_dec_t     dec
);
	import rvcsr_pkg::*;

	always_comb begin
		dec          = '0;
		dec.impl     = 1'b1;
		dec.kind     = KIND_STORE;
		dec.slot     = SLOT_MEDELEG;
		dec.writable = 1'b1;
		dec.wmode    = WMODE_PLAIN;
		case (addr)
			CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID, CSR_TIME: begin
				dec.kind     = KIND_ZERO;
				dec.writable = 1'b0;
			end
			CSR_MSTATUS: dec.kind = KIND_MSTATUS;
			CSR_MISA: begin
				dec.kind     = KIND_MISA;
				dec.writable = 1'b0;
			end
			CSR_MIE:     dec.kind = KIND_MIE;
			CSR_MIP:     dec.kind = KIND_MIP;
			CSR_SSTATUS: dec.kind = KIND_SSTATUS;
			CSR_SIE:     dec.kind = KIND_SIE;
			CSR_SIP:     dec.kind = KIND_SIP;
			CSR_MEDELEG:    dec.slot = SLOT_MEDELEG;
			CSR_MIDELEG:    dec.slot = SLOT_MIDELEG;
			CSR_MTVEC: begin
				dec.slot  = SLOT_MTVEC;
				dec.wmode = WMODE_TVEC;
			end
			CSR_MCOUNTEREN: dec.slot = SLOT_MCOUNTEREN;
			CSR_MSCRATCH:   dec.slot = SLOT_MSCRATCH;
			CSR_MEPC: begin
				dec.slot  = SLOT_MEPC;
				dec.wmode = WMODE_EPC;
			end
			CSR_MCAUSE:     dec.slot = SLOT_MCAUSE;
			CSR_MTVAL:      dec.slot = SLOT_MTVAL;
			CSR_MCYCLE:     dec.slot = SLOT_MCYCLE;
			CSR_MINSTRET:   dec.slot = SLOT_MINSTRET;
			CSR_CYCLE: begin
				dec.slot     = SLOT_MCYCLE;
				dec.writable = 1'b0;
			end
			CSR_INSTRET: begin
				dec.slot     = SLOT_MINSTRET;
				dec.writable = 1'b0;
			end
			CSR_STVEC: begin
				dec.slot  = SLOT_STVEC;
				dec.wmode = WMODE_TVEC;
			end
			CSR_SCOUNTEREN: dec.slot = SLOT_SCOUNTEREN;
			CSR_SSCRATCH:   dec.slot = SLOT_SSCRATCH;
			CSR_SEPC: begin
				dec.slot  = SLOT_SEPC;
				dec.wmode = WMODE_EPC;
			end
			CSR_SCAUSE:     dec.slot = SLOT_SCAUSE;
			CSR_STVAL:      dec.slot = SLOT_STVAL;
			CSR_SATP: begin
				dec.slot  = SLOT_SATP;
				dec.wmode = WMODE_SATP;
			end
			default: begin
				dec.impl     = 1'b0;
				dec.kind     = KIND_NONE;
				dec.writable = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/rvcsr_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CSR state
// Holds mstatus, mie, mip and the plain store; reads and applies write rules.
// ----------------------------------------------------------------------------
module rvcsr_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                we,
	input  wire rvcsr_pkg::csr_dec_t dec,
	input  wire logic [63:0]         wdata,
	output logic [63:0]              rdata
);
	import rvcsr_pkg::*;

	logic [STATUS_W-1:0] status_q;
	logic [IRQ_W-1:0]    mie_q;
	logic [IRQ_W-1:0]    mip_q;
	logic [63:0]         store_q [STORE_DEPTH];
	logic [63:0]         store_wdata;
	logic                store_wen;

	// Apply the per-register write rule for plain store entries
	always_comb begin
		store_wdata = wdata;
		store_wen   = we && (dec.kind == KIND_STORE) && dec.writable;
		case (dec.wmode)
			WMODE_TVEC:  store_wdata = {wdata[63:2], wdata[1] ? 2'b00 : wdata[1:0]};
			WMODE_EPC:   store_wdata = {wdata[63:2], 2'b00};
			WMODE_SATP: begin
				if (wdata[63:60] != TRANSLATION_BARE && wdata[63:60] != TRANSLATION_SV39)
					store_wen = 1'b0;
			end
			default:     store_wdata = wdata;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= MSTATUS_RESET;
			mie_q    <= '0;
			mip_q    <= '0;
			for (int i = 0; i < STORE_DEPTH; i++)
				store_q[i] <= '0;
		end else begin
			if (we) begin
				case (dec.kind)
					KIND_MSTATUS: status_q <= wdata[STATUS_W-1:0] & MSTATUS_KEEP;
					KIND_SSTATUS: status_q <= (status_q & ~SSTATUS_VIEW)
						| (wdata[STATUS_W-1:0] & SSTATUS_VIEW);
					KIND_MIE: mie_q <= wdata[IRQ_W-1:0] & IRQ_ALL;
					KIND_SIE: mie_q <= (mie_q & ~IRQ_SUPER) | (wdata[IRQ_W-1:0] & IRQ_SUPER);
					KIND_MIP: mip_q <= (mip_q & ~IRQ_SUPER) | (wdata[IRQ_W-1:0] & IRQ_SUPER);
					KIND_SIP: mip_q <= (mip_q & ~IRQ_SSIP) | (wdata[IRQ_W-1:0] & IRQ_SSIP);
					default: ;
				endcase
			end
			if (store_wen)
				store_q[dec.slot] <= store_wdata;
		end
	end

	always_comb begin
		case (dec.kind)
			KIND_MSTATUS: rdata = {{(64-STATUS_W){1'b0}}, status_q};
			KIND_SSTATUS: rdata = {{(64-STATUS_W){1'b0}}, status_q & SSTATUS_VIEW};
			KIND_MISA:    rdata = MISA_VALUE;
			KIND_MIE:     rdata = {{(64-IRQ_W){1'b0}}, mie_q};
			KIND_SIE:     rdata = {{(64-IRQ_W){1'b0}}, mie_q & IRQ_SUPER};
			KIND_MIP:     rdata = {{(64-IRQ_W){1'b0}}, mip_q};
			KIND_SIP:     rdata = {{(64-IRQ_W){1'b0}}, mip_q & IRQ_SUPER};
			KIND_STORE:   rdata = store_q[dec.slot];
			default:      rdata = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_status_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q & ~MSTATUS_KEEP) == '0)
		else $error("mstatus holds a bit outside its writable mask");
	a_irq_masks: assert property (@(posedge clk) disable iff (!arst_n)
		((mie_q & ~IRQ_ALL) == '0) && ((mip_q & ~IRQ_SUPER) == '0))
		else $error("mie or mip holds a bit outside its mask");
	a_epc_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(store_q[SLOT_MEPC][1:0] == 2'b00) && (store_q[SLOT_SEPC][1:0] == 2'b00))
		else $error("mepc or sepc has low bits set");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_rv64_csr_register_file.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RV64 CSR register file testbench
// Sends CSR reads and writes and predicts every result with its own CSR state
// (status, interrupt enables/pending, plain store). It checks each result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_rv64_csr_register_file;
	import rvcsr_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int DRAIN_CYCLES  = 4;
	localparam int REPORT_LIMIT  = 10;
	localparam int KNOWN_CSRS    = 31;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	csr_req_t req;
	logic     done;
	csr_rsp_t rsp;

	rv64_csr_register_file uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted CSR state, updated in item order as items are accepted
	logic [STATUS_W-1:0] csr_status;
	logic [IRQ_W-1:0]    csr_irq_en;
	logic [IRQ_W-1:0]    csr_irq_pend;
	logic [63:0]         csr_store [STORE_DEPTH];

	// Responses predicted but not yet seen on rsp, oldest first
	csr_rsp_t pending_rsp [$];
	csr_rsp_t oldest_rsp;

	int mismatch_count  = 0;
	int items_sent      = 0;
	int reads_sent      = 0;
	int writes_sent     = 0;
	int unimpl_sent     = 0;
	int results_checked = 0;
	int idle_burst      = 0;
	int cycle_count     = 0;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Slot of a plain read/write CSR, -1 for anything else
	function automatic int plain_slot_of(logic [11:0] a);
		case (a)
			CSR_MEDELEG:    return SLOT_MEDELEG;
			CSR_MIDELEG:    return SLOT_MIDELEG;
			CSR_MTVEC:      return SLOT_MTVEC;
			CSR_MCOUNTEREN: return SLOT_MCOUNTEREN;
			CSR_MSCRATCH:   return SLOT_MSCRATCH;
			CSR_MEPC:       return SLOT_MEPC;
			CSR_MCAUSE:     return SLOT_MCAUSE;
			CSR_MTVAL:      return SLOT_MTVAL;
			CSR_MCYCLE:     return SLOT_MCYCLE;
			CSR_MINSTRET:   return SLOT_MINSTRET;
			CSR_STVEC:      return SLOT_STVEC;
			CSR_SCOUNTEREN: return SLOT_SCOUNTEREN;
			CSR_SSCRATCH:   return SLOT_SSCRATCH;
			CSR_SEPC:       return SLOT_SEPC;
			CSR_SCAUSE:     return SLOT_SCAUSE;
			CSR_STVAL:      return SLOT_STVAL;
			CSR_SATP:       return SLOT_SATP;
			default:        return -1;
		endcase
	endfunction

	// Constants, counter aliases and masked views: implemented but not in the store
	function automatic bit is_view_csr(logic [11:0] a);
		case (a)
			CSR_MVENDORID, CSR_MARCHID, CSR_MIMPID, CSR_MHARTID,
			CSR_MSTATUS, CSR_MISA, CSR_MIE, CSR_MIP,
			CSR_CYCLE, CSR_TIME, CSR_INSTRET,
			CSR_SSTATUS, CSR_SIE, CSR_SIP:
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	// Apply one access to the predicted state and return the response it yields
	function automatic csr_rsp_t apply_csr_access(csr_req_t r);
		csr_rsp_t    o;
		int          slot;
		logic [63:0] v;
		o = '0;
		slot = plain_slot_of(r.csr_address);
		o.implemented = (slot >= 0) || is_view_csr(r.csr_address);
		if (!o.implemented)
			return o;
		if (r.cmd == CMD_READ) begin
			case (r.csr_address)
				CSR_MSTATUS: o.read_data = 64'(csr_status);
				CSR_MISA:    o.read_data = MISA_VALUE;
				CSR_MIE:     o.read_data = 64'(csr_irq_en);
				CSR_MIP:     o.read_data = 64'(csr_irq_pend);
				CSR_CYCLE:   o.read_data = csr_store[SLOT_MCYCLE];
				CSR_INSTRET: o.read_data = csr_store[SLOT_MINSTRET];
				CSR_SSTATUS: o.read_data = 64'(csr_status & SSTATUS_VIEW);
				CSR_SIE:     o.read_data = 64'(csr_irq_en & IRQ_SUPER);
				CSR_SIP:     o.read_data = 64'(csr_irq_pend & IRQ_SUPER);
				default:     o.read_data = (slot >= 0) ? csr_store[slot] : 64'd0;
			endcase
			return o;
		end
		v = r.write_data;
		case (r.csr_address)
			CSR_MSTATUS: csr_status = v[STATUS_W-1:0] & MSTATUS_KEEP;
			CSR_MIE:     csr_irq_en = v[IRQ_W-1:0] & IRQ_ALL;
			CSR_MIP:     csr_irq_pend = (csr_irq_pend & ~IRQ_SUPER) | (v[IRQ_W-1:0] & IRQ_SUPER);
			CSR_SSTATUS: csr_status = (csr_status & ~SSTATUS_VIEW)
				| (v[STATUS_W-1:0] & SSTATUS_VIEW);
			CSR_SIE:     csr_irq_en = (csr_irq_en & ~IRQ_SUPER) | (v[IRQ_W-1:0] & IRQ_SUPER);
			CSR_SIP:     csr_irq_pend = (csr_irq_pend & ~IRQ_SSIP) | (v[IRQ_W-1:0] & IRQ_SSIP);
			CSR_MTVEC, CSR_STVEC: begin
				// reserved modes 2 and 3 fall back to direct
				if (v[1])
					v[1:0] = 2'b00;
				csr_store[slot] = v;
			end
			CSR_MEPC, CSR_SEPC: begin
				v[1:0] = 2'b00;
				csr_store[slot] = v;
			end
			CSR_SATP: begin
				// drop the write unless the mode is Bare or Sv39
				if (v[63:60] == TRANSLATION_BARE || v[63:60] == TRANSLATION_SV39)
					csr_store[slot] = v;
			end
			default: begin
				// read-only addresses have no slot and fall through untouched
				if (slot >= 0)
					csr_store[slot] = v;
			end
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Implemented CSR by index, 0 .. KNOWN_CSRS-1
	function automatic logic [11:0] known_csr(int i);
		case (i)
			0:  return CSR_MVENDORID;
			1:  return CSR_MARCHID;
			2:  return CSR_MIMPID;
			3:  return CSR_MHARTID;
			4:  return CSR_MSTATUS;
			5:  return CSR_MISA;
			6:  return CSR_MEDELEG;
			7:  return CSR_MIDELEG;
			8:  return CSR_MIE;
			9:  return CSR_MTVEC;
			10: return CSR_MCOUNTEREN;
			11: return CSR_MSCRATCH;
			12: return CSR_MEPC;
			13: return CSR_MCAUSE;
			14: return CSR_MTVAL;
			15: return CSR_MIP;
			16: return CSR_MCYCLE;
			17: return CSR_MINSTRET;
			18: return CSR_CYCLE;
			19: return CSR_TIME;
			20: return CSR_INSTRET;
			21: return CSR_SSTATUS;
			22: return CSR_SIE;
			23: return CSR_STVEC;
			24: return CSR_SCOUNTEREN;
			25: return CSR_SSCRATCH;
			26: return CSR_SEPC;
			27: return CSR_SCAUSE;
			28: return CSR_STVAL;
			29: return CSR_SIP;
			default: return CSR_SATP;
		endcase
	endfunction

	// Write data: mostly random, with zero, all ones and single bits mixed in.
	// satp mostly gets a legal mode so writes land.
	function automatic logic [63:0] pick_write_data(logic [11:0] a);
		logic [63:0] v;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 8)
			v = '0;
		else if (r < 16)
			v = '1;
		else if (r < 24)
			v = 64'd1 << $urandom_range(0, 63);
		else
			v = {$urandom(), $urandom()};
		if (a == CSR_SATP && $urandom_range(0, 99) < 70)
			v[63:60] = $urandom_range(0, 1) ? TRANSLATION_SV39 : TRANSLATION_BARE;
		return v;
	endfunction

	// Idle cycles before the next item: mostly none or short, a few long,
	// and now and then a burst with no idling at all
	function automatic int pick_gap();
		int r;
		if (idle_burst > 0) begin
			idle_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			idle_burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Drive one item, hold it until accepted, then record its prediction.
	// start stays high on return so back-to-back items need no extra edge.
	task automatic issue_access(logic cmd, logic [11:0] addr, logic [63:0] data);
		csr_req_t item;
		int       gap;
		item.cmd = cmd;
		item.csr_address = addr;
		item.write_data = data;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			req <= '0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (busy);
		pending_rsp.push_back(apply_csr_access(item));
		items_sent++;
		if (cmd == CMD_WRITE)
			writes_sent++;
		else
			reads_sent++;
		if (plain_slot_of(addr) < 0 && !is_view_csr(addr))
			unimpl_sent++;
	endtask

	task automatic csr_read(logic [11:0] addr);
		issue_access(CMD_READ, addr, {$urandom(), $urandom()});
	endtask

	task automatic csr_write(logic [11:0] addr, logic [63:0] data);
		issue_access(CMD_WRITE, addr, data);
	endtask

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	task automatic note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
	endtask

	// Sample done/rsp at the edge that ends the result cycle; compare against
	// the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				note_mismatch("result with nothing outstanding", 64'd0, rsp.read_data);
			end else begin
				oldest_rsp = pending_rsp.pop_front();
				results_checked++;
				if (rsp.read_data !== oldest_rsp.read_data)
					note_mismatch("read_data", oldest_rsp.read_data, rsp.read_data);
				if (rsp.implemented !== oldest_rsp.implemented)
					note_mismatch("implemented", 64'(oldest_rsp.implemented),
						64'(rsp.implemented));
			end
		end
	end

	// Watchdog: end the run if it stalls
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------------

	// Reset value of mstatus, fixed IDs, misa and time; misa ignores writes
	task automatic test_constants();
		csr_read(CSR_MSTATUS);
		csr_read(CSR_MISA);
		csr_write(CSR_MISA, '1);
		csr_read(CSR_MISA);
		csr_write(CSR_MHARTID, '1);
		csr_read(CSR_MHARTID);
		csr_read(CSR_TIME);
	endtask

	// mstatus write mask and the sstatus view in both directions
	task automatic test_status_views();
		csr_write(CSR_MSTATUS, '1);
		csr_read(CSR_MSTATUS);
		csr_read(CSR_SSTATUS);
		csr_write(CSR_SSTATUS, '0);
		csr_read(CSR_MSTATUS);
	endtask

	// mie/mip masks, sie view, and sip touching only SSIP
	task automatic test_interrupts();
		csr_write(CSR_MIE, '1);
		csr_read(CSR_SIE);
		csr_write(CSR_MIP, '1);
		csr_write(CSR_SIP, '0);
		csr_read(CSR_MIP);
	endtask

	// Trap vector mode coercion and the cleared low bits of mepc
	task automatic test_trap_regs();
		csr_write(CSR_MTVEC, 64'hFFFF_FFFF_FFFF_FFFF);
		csr_read(CSR_MTVEC);
		csr_write(CSR_STVEC, 64'h0000_0000_8000_0001);
		csr_read(CSR_STVEC);
		csr_write(CSR_MEPC, '1);
		csr_read(CSR_MEPC);
	endtask

	// satp keeps Sv39 and drops an illegal mode
	task automatic test_satp();
		csr_write(CSR_SATP, {TRANSLATION_SV39, 60'hFFF_FFFF_FFFF_FFFF});
		csr_write(CSR_SATP, {4'hF, 60'h0});
		csr_read(CSR_SATP);
	endtask

	// cycle aliases mcycle and cannot be written itself
	task automatic test_counters();
		csr_write(CSR_MCYCLE, '1);
		csr_write(CSR_CYCLE, '0);
		csr_read(CSR_CYCLE);
	endtask

	// Unimplemented addresses at both ends of the space
	task automatic test_unimplemented();
		csr_write(12'hFFF, '1);
		csr_read(12'hFFF);
		csr_read(12'h000);
	endtask

	// ------------------------------------------------------------------------
	// Random test: mostly implemented CSRs, often a write followed by a read
	// of the same address, plus a share of arbitrary addresses
	// ------------------------------------------------------------------------
	task automatic test_random(int count);
		logic [11:0] addr;
		int          sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 85)
				addr = known_csr($urandom_range(0, KNOWN_CSRS - 1));
			else
				addr = 12'($urandom_range(0, 4095));
			if ($urandom_range(0, 99) < 30) begin
				csr_write(addr, pick_write_data(addr));
				csr_read(addr);
				sent += 2;
			end else begin
				if ($urandom_range(0, 1))
					csr_write(addr, pick_write_data(addr));
				else
					csr_read(addr);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		csr_status = MSTATUS_RESET;
		csr_irq_en = '0;
		csr_irq_pend = '0;
		for (int i = 0; i < STORE_DEPTH; i++)
			csr_store[i] = '0;

		// hold every input known and keep reset asserted
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_constants();
		test_status_views();
		test_interrupts();
		test_trap_regs();
		test_satp();
		test_counters();
		test_unimplemented();
		test_random(RANDOM_ITEMS);

		// drop start after the last item and let the pipeline drain
		start <= 1'b0;
		req <= '0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d reads, %0d writes, %0d to unimplemented addresses)",
			items_sent, reads_sent, writes_sent, unimpl_sent);
		$display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
src/rvcsr_pkg.sv
src/rvcsr_decode.sv
src/rvcsr_regs.sv
src/rv64_csr_register_file.sv
tb/sv/tb_rv64_csr_register_file.sv
